### design/otgt_pkg.sv
// shared types and constants for the online twiddle gain tuner
// no dependencies
`default_nettype none

package otgt_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_LAP    = 2'd1,
    CMD_INIT   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_INC   = 2'd1,
    PH_DEC   = 2'd2,
    PH_RSVD  = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_SAMPLE,
    ST_DIV,
    ST_PEN,
    ST_TUNE,
    ST_INIT,
    ST_OUT
  } state_t;

  // register indexes
  localparam logic [2:0] REG_KP   = 3'd0;
  localparam logic [2:0] REG_KI   = 3'd1;
  localparam logic [2:0] REG_KD   = 3'd2;
  localparam logic [2:0] REG_TOL  = 3'd3;
  localparam logic [2:0] REG_MINS = 3'd4;
  localparam logic [2:0] REG_MAXE = 3'd5;
  localparam logic [2:0] REG_IGN  = 3'd6;
  localparam logic [2:0] REG_LAP  = 3'd7;

  localparam int          CNT_W     = 17;
  localparam logic [16:0] COUNT_MAX = 17'd131071;
  localparam logic [63:0] PENALTY   = 64'd1000 << 16;

  // ceil(2^37 / 10), exact divide by ten for operands below 2^34
  localparam logic [34:0] RECIP_TEN = 35'h333333334;

  // controller to datapath commands
  typedef struct packed {
    logic do_sample;
    logic mod_start;
    logic div_start;
    logic do_pen;
    logic do_tune;
    logic do_init;
    logic do_clear;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
  } dp_stat_t;

  // x/10 rounded to nearest, ties away from zero, on 33 bit signed values
  function automatic logic signed [32:0] tenth(input logic signed [32:0] x);
    logic [32:0] mag;
    logic [33:0] num;
    logic [68:0] prod;
    logic [32:0] q;
    begin
      mag  = x[32] ? 33'(-x) : 33'(x);
      num  = 34'(mag) + 34'd5;
      // divide by ten as a reciprocal multiply
      prod = 69'(num) * 69'(RECIP_TEN);
      q    = 33'(prod >> 37);
      tenth = x[32] ? -$signed(q) : $signed(q);
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    begin
      if (v > 34'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -34'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

### design/otgt_ctrl.sv
// controller for the twiddle tuner: sequences sample, lap-end and init requests
// depends on otgt_pkg
`default_nettype none

module otgt_ctrl import otgt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire cmd_t     cmd,
  output logic          out_valid,
  input  wire logic     out_stall,
  output dp_cmd_t       dp_cmd,
  input  wire dp_stat_t dp_stat
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_SAMPLE: state_next = ST_MOD;
            CMD_LAP:    state_next = ST_DIV;
            CMD_INIT:   state_next = ST_INIT;
            default:    state_next = ST_OUT;
          endcase
        end
      end
      ST_MOD:    if (!dp_stat.div_busy) state_next = ST_SAMPLE;
      ST_SAMPLE: state_next = ST_OUT;
      ST_DIV:    if (!dp_stat.div_busy) state_next = ST_PEN;
      ST_PEN:    state_next = ST_TUNE;
      ST_TUNE:   state_next = ST_OUT;
      ST_INIT:   state_next = ST_OUT;
      ST_OUT:    if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
    dp_cmd    = '0;
    case (state)
      ST_IDLE: begin
        dp_cmd.div_start = in_valid && (cmd == CMD_LAP);
        dp_cmd.mod_start = in_valid && (cmd == CMD_SAMPLE);
      end
      ST_SAMPLE: dp_cmd.do_sample = 1'b1;
      ST_PEN:    dp_cmd.do_pen = 1'b1;
      ST_TUNE: begin
        dp_cmd.do_tune  = 1'b1;
        dp_cmd.do_clear = 1'b1;
      end
      ST_INIT:   dp_cmd.do_init = 1'b1;
      default:   dp_cmd = '0;
    endcase
  end

  // request taken only when idle
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != ST_IDLE))
    else $error("accepted request did not leave idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PEN) |-> $past(state) == ST_DIV)
    else $error("penalty step without division");

endmodule

`default_nettype wire

### design/otgt_div.sv
// restoring divider, one quotient bit per cycle, iteration count per request
// depends on otgt_pkg
`default_nettype none

module otgt_div import otgt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [6:0]  iters,
  input  wire logic [63:0] dividend,
  input  wire logic [16:0] divisor,
  output logic             busy,
  output logic [63:0]      quotient,
  output logic [16:0]      remainder
);

  logic [6:0]  count;
  logic [16:0] rem;
  logic [16:0] dvs;
  logic [17:0] trial;

  assign trial = {rem, quotient[63]} - {1'b0, dvs};
  assign remainder = rem;

  // shift and subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= iters;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[17]) begin
        rem      <= trial[16:0];
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem      <= {rem[15:0], quotient[63]};
        quotient <= {quotient[62:0], 1'b0};
      end
      count <= count - 7'd1;
      if (count == 7'd1) busy <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### design/otgt_dp.sv
// datapath: config registers, gains, deltas, lap accumulation and twiddle step
// depends on otgt_pkg and otgt_div
`default_nettype none

module otgt_dp import otgt_pkg::*; #(
  parameter int NUM_GAINS = 3,
  parameter int SUM_WIDTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_take,
  input  wire logic signed [15:0] track_error,
  input  wire logic [15:0]        speed,
  input  wire dp_cmd_t            dp_cmd,
  output dp_stat_t                dp_stat,
  output logic signed [31:0]      gain_p,
  output logic signed [31:0]      gain_i,
  output logic signed [31:0]      gain_d,
  output logic                    lap_done,
  output logic                    off_track,
  output logic                    tuning_active
);

  localparam logic [63:0] SMAX = {64{1'b1}} >> (64 - SUM_WIDTH);

  logic signed [31:0] init_k [3];
  logic [30:0] tol;
  logic [15:0] min_speed, ign, lap;
  logic [14:0] max_err;

  logic signed [31:0] gains [3];
  logic signed [31:0] deltas [3];
  logic [63:0] best_err, error_sum, err;
  logic [16:0] sample_count;
  phase_t phase;
  logic [1:0] gidx;
  logic off_flag;
  logic [15:0] lap_count, change_count;
  logic signed [15:0] te;
  logic [15:0] sp;

  logic div_busy;
  logic [63:0] quot;
  logic [16:0] mod_rem;
  logic signed [17:0] div_s;
  logic [16:0] pos, modv;
  logic [31:0] sq;
  logic [64:0] sum_add;
  logic signed [33:0] dsum;
  logic [1:0] gnext;
  logic unused;

  assign unused = ^{lap_count, change_count};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init_k[0] <= '0; init_k[1] <= '0; init_k[2] <= '0;
      tol <= 31'd6554; min_speed <= 16'd1024; max_err <= 15'd1536;
      ign <= 16'd100; lap <= 16'd5500;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_KP:   init_k[0] <= cfg_data;
        REG_KI:   init_k[1] <= cfg_data;
        REG_KD:   init_k[2] <= cfg_data;
        REG_TOL:  tol <= cfg_data[30:0];
        REG_MINS: min_speed <= cfg_data[15:0];
        REG_MAXE: max_err <= cfg_data[14:0];
        REG_IGN:  ign <= cfg_data[15:0];
        REG_LAP:  lap <= cfg_data[15:0];
        default:  tol <= tol;
      endcase
    end
  end

  // request payload capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      te <= track_error;
      sp <= speed;
    end
  end

  assign div_s = $signed({1'b0, sample_count}) - $signed({2'b0, ign});
  assign modv  = 17'(lap) + 17'(ign);

  // shared serial unit: lap window remainder on samples, mean error on lap end
  otgt_div u_div (
    .clk(clk), .rst(rst), .start(dp_cmd.div_start || dp_cmd.mod_start),
    .iters(dp_cmd.mod_start ? 7'd17 : 7'd64),
    .dividend(dp_cmd.mod_start ? {sample_count, 47'b0} : error_sum),
    .divisor(dp_cmd.mod_start ? modv : div_s[16:0]),
    .busy(div_busy), .quotient(quot), .remainder(mod_rem)
  );
  assign dp_stat.div_busy = div_busy;

  // sample position in lap window, squared error, error sum, delta total and next gain index
  always_comb begin
    pos  = (modv != '0) ? mod_rem : sample_count;
    sq   = 32'($signed(te) * $signed(te));
    sum_add = 65'(error_sum) + 65'(sq);
    dsum = '0;
    for (int i = 0; i < 3; i++) if (i < NUM_GAINS) dsum = dsum + 34'(deltas[i]);
    gnext = (32'(gidx) + 32'd1 >= NUM_GAINS) ? 2'd0 : gidx + 2'd1;
  end

  assign tuning_active = dsum > $signed({3'b0, tol});

  // state update
  always_ff @(posedge clk) begin
    logic signed [31:0] g, d, dg, gn, dn;
    logic [1:0] k;
    logic [63:0] e;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        gains[i] <= '0; deltas[i] <= '0;
      end
      best_err <= '1; error_sum <= '0; sample_count <= '0; phase <= PH_FIRST;
      gidx <= '0; off_flag <= 1'b0; lap_count <= '0; change_count <= '0;
    end else begin
      if (dp_cmd.do_sample) begin
        if ({1'b0, sample_count} > {ign, 2'b0})
          off_flag <= (sp < min_speed) || (te > $signed({1'b0, max_err}));
        if (pos > 17'(ign))
          error_sum <= (sum_add > 65'(SMAX)) ? SMAX : sum_add[63:0];
        if (sample_count < COUNT_MAX) sample_count <= sample_count + 17'd1;
      end
      if (dp_cmd.do_pen) begin
        e = (div_s > 0) ? quot : '1;
        if (tuning_active && off_flag) e = (e > ~PENALTY) ? '1 : e + PENALTY;
        err <= e;
      end
      if (dp_cmd.do_tune) begin
        k  = gidx;
        g  = gains[k];
        d  = deltas[k];
        if (tuning_active) begin
          case (phase)
            PH_INC: begin
              if (err < best_err) begin
                best_err <= err;
                dn = sat32(34'(d) + 34'(tenth(33'(d))));
                deltas[k] <= dn;
                gidx <= gnext;
                gains[gnext] <= sat32(34'(gains[gnext]) +
                  34'((gnext == k) ? dn : deltas[gnext]));
              end else begin
                gains[k] <= sat32(34'(g) - 34'(d) - 34'(d));
                phase <= PH_DEC;
              end
            end
            PH_DEC: begin
              phase <= PH_INC;
              if (err < best_err) begin
                best_err <= err;
                dn = sat32(34'(d) + 34'(tenth(33'(d))));
                gn = g;
              end else begin
                gn = sat32(34'(g) + 34'(d));
                dn = 32'(33'(d) - tenth(33'(d)));
              end
              deltas[k] <= dn;
              gidx <= gnext;
              if (gnext == k) gains[k] <= sat32(34'(gn) + 34'(dn));
              else begin
                gains[k] <= gn;
                gains[gnext] <= sat32(34'(gains[gnext]) + 34'(deltas[gnext]));
              end
            end
            default: begin
              best_err <= err;
              gains[k] <= sat32(34'(g) + 34'(d));
              phase <= PH_INC;
            end
          endcase
          change_count <= change_count + 16'd1;
        end
        lap_count <= lap_count + 16'd1;
      end
      if (dp_cmd.do_clear) begin
        error_sum <= '0; sample_count <= '0; off_flag <= 1'b0;
      end
      if (dp_cmd.do_init) begin
        for (int i = 0; i < 3; i++) begin
          dg = 32'(tenth(33'(init_k[i])));
          gains[i] <= init_k[i];
          deltas[i] <= dg;
        end
        best_err <= '1; phase <= PH_FIRST; gidx <= '0;
        lap_count <= '0; change_count <= '0;
        error_sum <= '0; sample_count <= '0; off_flag <= 1'b0;
      end
    end
  end

  assign gain_p    = gains[0];
  assign gain_i    = gains[1];
  assign gain_d    = gains[2];
  assign lap_done  = sample_count >= 17'(lap);
  assign off_track = off_flag;

  a_sum_cap: assert property (@(posedge clk) disable iff (rst) error_sum <= SMAX)
    else $error("error sum beyond saturation");
  a_idx: assert property (@(posedge clk) disable iff (rst) 32'(gidx) < NUM_GAINS)
    else $error("gain index out of range");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.do_clear |=> (sample_count == '0))
    else $error("lap state not cleared");

endmodule

`default_nettype wire

### design/online_twiddle_gain_tuner.sv
// Online twiddle PID gain tuner. One request is taken at a time; a result
// follows each request. The unused command code goes straight to the result;
// init runs its init step, a sample waits on the 17-step serial remainder
// that places the sample in the lap window and is then accumulated, and a lap
// end waits on the 64-step serial divider that forms the mean lap error, then
// runs its penalty and tuning steps. Result holds until taken; the next
// request can be taken in the cycle after the result is taken.
// depends on otgt_pkg, otgt_ctrl, otgt_dp
`default_nettype none

module online_twiddle_gain_tuner import otgt_pkg::*; #(
  parameter int NUM_GAINS = 3,
  parameter int SUM_WIDTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         cmd,
  input  wire logic signed [15:0] track_error,
  input  wire logic [15:0]        speed,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      gain_p,
  output logic signed [31:0]      gain_i,
  output logic signed [31:0]      gain_d,
  output logic                    lap_done,
  output logic                    off_track,
  output logic                    tuning_active
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  otgt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd_t'(cmd)), .out_valid(out_valid), .out_stall(out_stall),
    .dp_cmd(dp_cmd), .dp_stat(dp_stat)
  );

  otgt_dp #(.NUM_GAINS(NUM_GAINS), .SUM_WIDTH(SUM_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_valid), .cfg_idx(cfg_index),
    .cfg_data(cfg_data), .in_take(in_valid && !in_stall),
    .track_error(track_error), .speed(speed), .dp_cmd(dp_cmd), .dp_stat(dp_stat),
    .gain_p(gain_p), .gain_i(gain_i), .gain_d(gain_d), .lap_done(lap_done),
    .off_track(off_track), .tuning_active(tuning_active)
  );

endmodule

`default_nettype wire

### tb/sv/tb_online_twiddle_gain_tuner.sv
// testbench for the online twiddle gain tuner: directed and random requests
// checked against a behavioural predictor of the twiddle tuning step
// depends on otgt_pkg and online_twiddle_gain_tuner
`default_nettype none

module tb_online_twiddle_gain_tuner;
  import otgt_pkg::*;

  typedef struct {
    logic signed [31:0] p;
    logic signed [31:0] i;
    logic signed [31:0] d;
    logic               lap;
    logic               off;
    logic               tune;
  } gains_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = '0;
  logic signed [15:0] track_error = '0;
  logic [15:0] speed = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] gain_p, gain_i, gain_d;
  logic lap_done, off_track, tuning_active;

  online_twiddle_gain_tuner uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .track_error(track_error), .speed(speed),
    .out_valid(out_valid), .out_stall(out_stall),
    .gain_p(gain_p), .gain_i(gain_i), .gain_d(gain_d),
    .lap_done(lap_done), .off_track(off_track), .tuning_active(tuning_active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idling mode: 0 none, 1 sender gaps, 2 receiver stalls, 3 both light
  int idle_mode = 0;
  int mismatches = 0;
  gains_out_t expected_gains[$];

  // predictor copy of the configuration
  logic [31:0] set_kp, set_ki, set_kd;
  int unsigned set_tol, set_min_speed, set_max_err, set_ignore, set_lap;

  // predictor copy of the tuner state
  int gain_val[3];
  int step_val[3];
  logic [63:0] best_lap_err;
  logic [63:0] lap_err_sum;
  int unsigned sample_cnt;
  phase_t tune_phase;
  int unsigned gain_sel;
  logic off_seen;

  function automatic longint round_tenth(longint x);
    if (x >= 0) return (x + 5) / 10;
    return -((-x + 5) / 10);
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint step_total();
    return longint'(step_val[0]) + step_val[1] + step_val[2];
  endfunction

  function automatic void nudge_gain();
    gain_val[gain_sel] = clip32(longint'(gain_val[gain_sel]) + step_val[gain_sel]);
  endfunction

  function automatic void grow_step();
    step_val[gain_sel] = clip32(longint'(step_val[gain_sel])
                                + round_tenth(step_val[gain_sel]));
  endfunction

  function automatic void clear_lap_state();
    lap_err_sum = '0;
    sample_cnt = 0;
    off_seen = 1'b0;
  endfunction

  function automatic void tuner_reset();
    set_kp = '0; set_ki = '0; set_kd = '0;
    set_tol = 6554; set_min_speed = 1024; set_max_err = 1536;
    set_ignore = 100; set_lap = 5500;
    for (int k = 0; k < 3; k++) begin
      gain_val[k] = 0;
      step_val[k] = 0;
    end
    best_lap_err = '1;
    tune_phase = PH_FIRST;
    gain_sel = 0;
    clear_lap_state();
  endfunction

  function automatic void tuner_sample(logic signed [15:0] te, logic [15:0] sp);
    int cte;
    int unsigned modv, pos;
    logic [63:0] sq;
    cte = te;
    modv = set_lap + set_ignore;
    pos = (modv != 0) ? sample_cnt % modv : sample_cnt;
    if (sample_cnt > 4 * set_ignore)
      off_seen = (sp < set_min_speed) || (cte > int'(set_max_err));
    if (pos > set_ignore) begin
      sq = 64'(cte * cte);
      lap_err_sum = (lap_err_sum > ~64'd0 - sq) ? ~64'd0 : lap_err_sum + sq;
    end
    if (sample_cnt < 131071) sample_cnt++;
  endfunction

  function automatic void tuner_lap_end();
    longint dv;
    logic [63:0] err;
    int unsigned k;
    dv = longint'(sample_cnt) - longint'(set_ignore);
    err = (dv > 0) ? lap_err_sum / 64'(dv) : ~64'd0;
    k = gain_sel;
    if (step_total() > longint'(set_tol)) begin
      if (off_seen) err = (err > ~64'd0 - PENALTY) ? ~64'd0 : err + PENALTY;
      if (tune_phase == PH_INC) begin
        if (err < best_lap_err) begin
          best_lap_err = err;
          grow_step();
          gain_sel = (gain_sel + 1) % 3;
          nudge_gain();
        end else begin
          gain_val[k] = clip32(longint'(gain_val[k]) - 2 * longint'(step_val[k]));
          tune_phase = PH_DEC;
        end
      end else if (tune_phase == PH_DEC) begin
        tune_phase = PH_INC;
        if (err < best_lap_err) begin
          best_lap_err = err;
          grow_step();
        end else begin
          nudge_gain();
          step_val[k] = int'(longint'(step_val[k]) - round_tenth(step_val[k]));
        end
        gain_sel = (gain_sel + 1) % 3;
        nudge_gain();
      end else begin
        // first phase, and the unused phase code behaves the same
        best_lap_err = err;
        nudge_gain();
        tune_phase = PH_INC;
      end
    end
    clear_lap_state();
  endfunction

  function automatic void tuner_init();
    gain_val[0] = set_kp;
    gain_val[1] = set_ki;
    gain_val[2] = set_kd;
    for (int k = 0; k < 3; k++) step_val[k] = int'(round_tenth(gain_val[k]));
    best_lap_err = '1;
    tune_phase = PH_FIRST;
    gain_sel = 0;
    clear_lap_state();
  endfunction

  function automatic gains_out_t tuner_step(cmd_t c, logic signed [15:0] te,
                                            logic [15:0] sp);
    gains_out_t r;
    case (c)
      CMD_SAMPLE: tuner_sample(te, sp);
      CMD_LAP:    tuner_lap_end();
      CMD_INIT:   tuner_init();
      default: ;
    endcase
    r.p = gain_val[0];
    r.i = gain_val[1];
    r.d = gain_val[2];
    r.lap = sample_cnt >= set_lap;
    r.off = off_seen;
    r.tune = step_total() > longint'(set_tol);
    return r;
  endfunction

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else case (idle_mode)
      2: out_stall <= $urandom_range(99) < 49;
      3: out_stall <= $urandom_range(99) < 15;
      default: out_stall <= 1'b0;
    endcase
  end

  // result checker
  always @(posedge clk) begin
    gains_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_gains.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: p=%h i=%h d=%h",
                                       gain_p, gain_i, gain_d);
      end else begin
        e = expected_gains.pop_front();
        if (gain_p !== e.p || gain_i !== e.i || gain_d !== e.d ||
            lap_done !== e.lap || off_track !== e.off || tuning_active !== e.tune) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp p=%h i=%h d=%h lap=%b off=%b tune=%b, got p=%h i=%h d=%h lap=%b off=%b tune=%b",
                     e.p, e.i, e.d, e.lap, e.off, e.tune,
                     gain_p, gain_i, gain_d, lap_done, off_track, tuning_active);
        end
      end
    end
  end

  // send one request; entered and left at a falling edge
  task automatic send_req(cmd_t c, logic [15:0] te, logic [15:0] sp);
    int gap;
    gap = (idle_mode == 1) ? 49 : (idle_mode == 3) ? 15 : 0;
    while ($urandom_range(99) < gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = c;
    track_error = te;
    speed = sp;
    do @(posedge clk); while (in_stall);
    expected_gains.push_back(tuner_step(c, te, sp));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_gains.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KP:   set_kp = val;
      REG_KI:   set_ki = val;
      REG_KD:   set_kd = val;
      REG_TOL:  set_tol = val[30:0];
      REG_MINS: set_min_speed = val[15:0];
      REG_MAXE: set_max_err = val[14:0];
      REG_IGN:  set_ignore = val[15:0];
      default:  set_lap = val[15:0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(logic [31:0] kp, ki, kd, tol, mins, maxe, ign, lap);
    wait_idle();
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_TOL, tol);
    write_reg(REG_MINS, mins);
    write_reg(REG_MAXE, maxe);
    write_reg(REG_IGN, ign);
    write_reg(REG_LAP, lap);
  endtask

  // reset defaults: idle command, empty lap, one sample, then init with defaults and a lap
  task automatic test_defaults();
    send_req(CMD_NONE, 16'h7fff, 16'hffff);
    send_req(CMD_LAP, '0, '0);
    send_req(CMD_SAMPLE, 16'h8000, 16'h0000);
    send_req(CMD_INIT, '0, '0);
    send_req(CMD_LAP, '0, '0);
  endtask

  // extreme gains and limits with off track; the initial deltas cancel, so no phase is tuned
  task automatic test_extremes();
    write_all(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'd0,
              32'hffff, 32'h7fff, 32'd0, 32'd1);
    send_req(CMD_INIT, '0, '0);
    send_req(CMD_SAMPLE, 16'h7fff, 16'hffff);
    send_req(CMD_SAMPLE, 16'h8000, 16'h0000);
    send_req(CMD_SAMPLE, 16'h7fff, 16'hffff);
    for (int n = 0; n < 6; n++) begin
      send_req(CMD_SAMPLE, n[0] ? 16'h8000 : 16'h0100, 16'h1234);
      send_req(CMD_LAP, '0, '0);
    end
    send_req(CMD_NONE, '0, '0);
    // tolerance at its top keeps tuning off, with ignore count and lap at their top
    write_all(32'h00010000, 32'h00020000, 32'h00008000, 32'h7fffffff,
              32'h0, 32'h0, 32'hffff, 32'hffff);
    send_req(CMD_INIT, '0, '0);
    send_req(CMD_SAMPLE, 16'h0400, 16'h0400);
    send_req(CMD_LAP, '0, '0);
  endtask

  function automatic logic [15:0] pick_error();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  // random laps of twiddle tuning under one idling mode
  task automatic test_twiddle(int mode, int laps);
    int unsigned ign, lap, n;
    idle_mode = mode;
    ign = $urandom_range(4);
    lap = $urandom_range(1, 10);
    write_all($urandom_range(1) ? $urandom : 32'($signed($urandom_range(4000000)) - 2000000),
              32'($signed($urandom_range(2000000)) - 1000000),
              $urandom_range(1500000),
              $urandom_range(3) == 0 ? $urandom : $urandom_range(20000),
              $urandom_range(3) == 0 ? $urandom : $urandom_range(300),
              $urandom_range(3) == 0 ? $urandom : $urandom_range(200, 600),
              ign, lap);
    send_req(CMD_INIT, '0, '0);
    for (int l = 0; l < laps; l++) begin
      n = $urandom_range(9) == 0 ? $urandom_range(ign) : $urandom_range(ign + 1, lap + ign + 3);
      for (int s = 0; s < n; s++) send_req(CMD_SAMPLE, pick_error(), 16'($urandom));
      if ($urandom_range(19) == 0) send_req(CMD_NONE, 16'($urandom), 16'($urandom));
      if ($urandom_range(29) == 0) send_req(CMD_INIT, '0, '0);
      send_req(CMD_LAP, '0, '0);
    end
  endtask

  initial begin
    tuner_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_defaults();
    test_extremes();
    for (int r = 0; r < 12; r++) test_twiddle(r % 4, 13);
    in_valid = 1'b0;
    while (expected_gains.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #10000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
